@@ rtl/core/ocr_pkg.sv @@
`timescale 1ns / 1ps

package ocr_pkg;

    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STEPS   = 33;
    localparam int DIV_STEPS    = 33;
    localparam int BACK_STAGES  = 4;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + BACK_STAGES;

    localparam logic [65:0] MIN_SQ = 66'd429497;

    localparam logic [2:0] CFG_YAW_COS          = 3'd0;
    localparam logic [2:0] CFG_YAW_SIN          = 3'd1;
    localparam logic [2:0] CFG_DISTANCE_SCALE   = 3'd2;
    localparam logic [2:0] CFG_MINIMUM_DISTANCE = 3'd3;
    localparam logic [2:0] CFG_VERTICAL_OFFSET  = 3'd4;
    localparam logic [2:0] CFG_SIDEWAYS_OFFSET  = 3'd5;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
    } cam_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] new_eye_x;
        logic signed [31:0] new_eye_y;
        logic signed [31:0] new_eye_z;
        logic signed [31:0] new_look_x;
        logic signed [31:0] new_look_y;
        logic signed [31:0] new_look_z;
    } res_t;

    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [32:0] tz;
        logic [48:0]        rxm;
        logic [48:0]        rym;
        logic [48:0]        rzm;
        logic               rx_neg;
        logic               ry_neg;
        logic               rz_neg;
        logic [32:0]        vxm;
        logic [32:0]        vym;
        logic               vx_neg;
        logic               vy_neg;
        logic               short_v;
        logic               short_h;
    } p1_t;

    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [32:0] tz;
        logic               rx_neg;
        logic               ry_neg;
        logic               rz_neg;
        logic               px_neg;
        logic               py_neg;
        logic [48:0]        dprod;
        logic               short_v;
        logic               short_h;
    } p2_t;

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        if ((v[45:31] == '0) || (v[45:31] == '1)) begin
            r = v[31:0];
        end else if (v[45]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ocr_front.sv @@
`timescale 1ns / 1ps

module ocr_front (
    input  logic                clk,
    input  logic                en,
    input  ocr_pkg::cam_t       cam,
    input  logic signed [15:0]  yaw_cos,
    input  logic signed [15:0]  yaw_sin,
    input  logic signed [31:0]  vertical_offset,
    output logic [65:0]         vsq,
    output logic [65:0]         hsq,
    output ocr_pkg::p1_t        p1
);
    import ocr_pkg::*;

    logic signed [32:0] s0_vx_reg, s0_vy_reg, s0_vz_reg;
    logic signed [31:0] s0_lx_reg, s0_ly_reg, s0_lz_reg;

    logic signed [65:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [48:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [32:0] s1_vx_reg, s1_vy_reg, s1_vz_reg, s1_tz_reg;
    logic signed [31:0] s1_lx_reg, s1_ly_reg;

    logic [65:0]        vsq_reg, hsq_reg;
    logic signed [49:0] rx_reg, ry_reg;
    logic signed [46:0] rz_reg;
    logic signed [32:0] s2_vx_reg, s2_vy_reg, s2_tz_reg;
    logic signed [31:0] s2_lx_reg, s2_ly_reg;

    logic [49:0] rx_abs, ry_abs;
    logic [46:0] rz_abs;
    logic [32:0] vx_abs, vy_abs;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_vx_reg <= {cam.eye_x[31], cam.eye_x} - {cam.look_x[31], cam.look_x};
            s0_vy_reg <= {cam.eye_y[31], cam.eye_y} - {cam.look_y[31], cam.look_y};
            s0_vz_reg <= {cam.eye_z[31], cam.eye_z} - {cam.look_z[31], cam.look_z};
            s0_lx_reg <= cam.look_x;
            s0_ly_reg <= cam.look_y;
            s0_lz_reg <= cam.look_z;

            sqx_reg   <= s0_vx_reg * s0_vx_reg;
            sqy_reg   <= s0_vy_reg * s0_vy_reg;
            sqz_reg   <= s0_vz_reg * s0_vz_reg;
            pxc_reg   <= s0_vx_reg * yaw_cos;
            pys_reg   <= s0_vy_reg * yaw_sin;
            pxs_reg   <= s0_vx_reg * yaw_sin;
            pyc_reg   <= s0_vy_reg * yaw_cos;
            s1_vx_reg <= s0_vx_reg;
            s1_vy_reg <= s0_vy_reg;
            s1_vz_reg <= s0_vz_reg;
            s1_lx_reg <= s0_lx_reg;
            s1_ly_reg <= s0_ly_reg;
            s1_tz_reg <= {s0_lz_reg[31], s0_lz_reg} + {vertical_offset[31], vertical_offset};

            vsq_reg   <= sqx_reg + sqy_reg + sqz_reg;
            hsq_reg   <= sqx_reg + sqy_reg;
            rx_reg    <= {pxc_reg[48], pxc_reg} - {pys_reg[48], pys_reg};
            ry_reg    <= {pxs_reg[48], pxs_reg} + {pyc_reg[48], pyc_reg};
            rz_reg    <= {s1_vz_reg, 14'b0};
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_lx_reg <= s1_lx_reg;
            s2_ly_reg <= s1_ly_reg;
            s2_tz_reg <= s1_tz_reg;
        end
    end

    always_comb
    begin
        rx_abs = rx_reg[49] ? -rx_reg : rx_reg;
        ry_abs = ry_reg[49] ? -ry_reg : ry_reg;
        rz_abs = rz_reg[46] ? -rz_reg : rz_reg;
        vx_abs = s2_vx_reg[32] ? -s2_vx_reg : s2_vx_reg;
        vy_abs = s2_vy_reg[32] ? -s2_vy_reg : s2_vy_reg;

        p1.lx      = s2_lx_reg;
        p1.ly      = s2_ly_reg;
        p1.tz      = s2_tz_reg;
        p1.rxm     = rx_abs[48:0];
        p1.rym     = ry_abs[48:0];
        p1.rzm     = {2'b0, rz_abs};
        p1.rx_neg  = rx_reg[49];
        p1.ry_neg  = ry_reg[49];
        p1.rz_neg  = rz_reg[46];
        p1.vxm     = vx_abs;
        p1.vym     = vy_abs;
        p1.vx_neg  = s2_vx_reg[32];
        p1.vy_neg  = s2_vy_reg[32];
        p1.short_v = vsq_reg < MIN_SQ;
        p1.short_h = hsq_reg < MIN_SQ;
    end

    assign vsq = vsq_reg;
    assign hsq = hsq_reg;

endmodule

@@ rtl/core/ocr_sqrt.sv @@
`timescale 1ns / 1ps

module ocr_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [65:0] radicand,
    output logic [32:0] root
);
    import ocr_pkg::*;

    typedef struct packed {
        logic [65:0] rad;
        logic [35:0] rem;
        logic [32:0] root;
    } sq_st_t;

    function automatic sq_st_t sq_step(input sq_st_t s);
        sq_st_t      n;
        logic [35:0] rem2;
        logic [35:0] trial;
        rem2  = {s.rem[33:0], s.rad[65:64]};
        trial = {1'b0, s.root, 2'b01};
        n.rad = {s.rad[63:0], 2'b00};
        if (rem2 >= trial)
        begin
            n.rem  = rem2 - trial;
            n.root = {s.root[31:0], 1'b1};
        end else begin
            n.rem  = rem2;
            n.root = {s.root[31:0], 1'b0};
        end
        return n;
    endfunction

    sq_st_t st_reg  [SQRT_STEPS];
    sq_st_t st_next [SQRT_STEPS];
    sq_st_t st_init;

    assign st_init = '{rad: radicand, rem: '0, root: '0};

    assign st_next[0] = sq_step(st_init);
    for (genvar i = 1; i < SQRT_STEPS; i++)
    begin : g_step
        assign st_next[i] = sq_step(st_reg[i-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign root = st_reg[SQRT_STEPS-1].root;

endmodule

@@ rtl/core/ocr_div.sv @@
`timescale 1ns / 1ps

module ocr_div (
    input  logic        clk,
    input  logic        en,
    input  logic [65:0] num,
    input  logic [32:0] den,
    output logic [32:0] quo
);
    import ocr_pkg::*;

    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] low;
        logic [32:0] den;
    } dv_st_t;

    function automatic dv_st_t dv_step(input dv_st_t s);
        dv_st_t      n;
        logic [33:0] r2;
        logic [33:0] diff;
        r2    = {s.rem, s.low[32]};
        diff  = r2 - {1'b0, s.den};
        n.den = s.den;
        if (r2 >= {1'b0, s.den})
        begin
            n.rem = diff[32:0];
            n.low = {s.low[31:0], 1'b1};
        end else begin
            n.rem = r2[32:0];
            n.low = {s.low[31:0], 1'b0};
        end
        return n;
    endfunction

    dv_st_t st_reg  [DIV_STEPS];
    dv_st_t st_next [DIV_STEPS];
    dv_st_t st_init;

    assign st_init = '{rem: num[65:33], low: num[32:0], den: den};

    assign st_next[0] = dv_step(st_init);
    for (genvar i = 1; i < DIV_STEPS; i++)
    begin : g_step
        assign st_next[i] = dv_step(st_reg[i-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign quo = st_reg[DIV_STEPS-1].low;

endmodule

@@ rtl/core/ocr_back.sv @@
`timescale 1ns / 1ps

module ocr_back (
    input  logic                clk,
    input  logic                en,
    input  ocr_pkg::p2_t        p2,
    input  logic [32:0]         qx,
    input  logic [32:0]         qy,
    input  logic [32:0]         qz,
    input  logic [32:0]         qpx,
    input  logic [32:0]         qpy,
    input  logic [30:0]         minimum_distance,
    input  logic [31:0]         off_mag,
    input  logic                off_neg,
    input  logic                off_nz,
    output ocr_pkg::res_t       res
);
    import ocr_pkg::*;

    logic [40:0]        b1_d_reg;
    logic [32:0]        b1_ux_reg, b1_uy_reg, b1_uz_reg;
    logic               b1_xn_reg, b1_yn_reg, b1_zn_reg;
    logic [63:0]        b1_shx_reg, b1_shy_reg;
    logic               b1_shxn_reg, b1_shyn_reg;
    logic signed [31:0] b1_lx_reg, b1_ly_reg;
    logic signed [32:0] b1_tz_reg;
    logic               b1_ok_reg;

    logic [56:0]        b2_plx_reg, b2_ply_reg, b2_plz_reg;
    logic [49:0]        b2_phx_reg, b2_phy_reg, b2_phz_reg;
    logic               b2_xn_reg, b2_yn_reg, b2_zn_reg;
    logic signed [31:0] b2_tx_reg, b2_ty_reg, b2_tz_reg;
    logic               b2_ok_reg;

    logic signed [44:0] b3_ex_reg, b3_ey_reg, b3_ez_reg;
    logic signed [31:0] b3_tx_reg, b3_ty_reg, b3_tz_reg;
    logic               b3_ok_reg;

    res_t res_reg;

    logic [40:0]        d_scaled;
    logic [40:0]        d_min;
    logic signed [35:0] shx_s, shy_s;
    logic signed [45:0] tx_w, ty_w, tz_w;
    logic [73:0]        ex_sum, ey_sum, ez_sum;
    logic signed [44:0] ex_mag, ey_mag, ez_mag;
    logic signed [45:0] nx_w, ny_w, nz_w;

    always_comb
    begin
        d_scaled = p2.dprod[48:8];
        d_min    = {10'b0, minimum_distance};

        shx_s = {2'b0, b1_shx_reg[63:30]};
        shy_s = {2'b0, b1_shy_reg[63:30]};
        if (b1_shxn_reg)
        begin
            shx_s = -shx_s;
        end
        if (b1_shyn_reg)
        begin
            shy_s = -shy_s;
        end
        tx_w = {{14{b1_lx_reg[31]}}, b1_lx_reg} + {{10{shx_s[35]}}, shx_s};
        ty_w = {{14{b1_ly_reg[31]}}, b1_ly_reg} + {{10{shy_s[35]}}, shy_s};
        tz_w = {{13{b1_tz_reg[32]}}, b1_tz_reg};

        ex_sum = {b2_phx_reg, 24'b0} + {17'b0, b2_plx_reg};
        ey_sum = {b2_phy_reg, 24'b0} + {17'b0, b2_ply_reg};
        ez_sum = {b2_phz_reg, 24'b0} + {17'b0, b2_plz_reg};
        ex_mag = {1'b0, ex_sum[73:30]};
        ey_mag = {1'b0, ey_sum[73:30]};
        ez_mag = {1'b0, ez_sum[73:30]};

        nx_w = {{14{b3_tx_reg[31]}}, b3_tx_reg} + {b3_ex_reg[44], b3_ex_reg};
        ny_w = {{14{b3_ty_reg[31]}}, b3_ty_reg} + {b3_ey_reg[44], b3_ey_reg};
        nz_w = {{14{b3_tz_reg[31]}}, b3_tz_reg} + {b3_ez_reg[44], b3_ez_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_d_reg    <= (d_scaled < d_min) ? d_min : d_scaled;
            b1_ux_reg   <= qx;
            b1_uy_reg   <= qy;
            b1_uz_reg   <= qz;
            b1_xn_reg   <= p2.rx_neg;
            b1_yn_reg   <= p2.ry_neg;
            b1_zn_reg   <= p2.rz_neg;
            b1_shx_reg  <= qpx[31:0] * off_mag;
            b1_shy_reg  <= qpy[31:0] * off_mag;
            b1_shxn_reg <= p2.px_neg ^ off_neg;
            b1_shyn_reg <= p2.py_neg ^ off_neg;
            b1_lx_reg   <= p2.lx;
            b1_ly_reg   <= p2.ly;
            b1_tz_reg   <= p2.tz;
            b1_ok_reg   <= !p2.short_v && !(off_nz && p2.short_h);

            b2_plx_reg <= b1_ux_reg * b1_d_reg[23:0];
            b2_ply_reg <= b1_uy_reg * b1_d_reg[23:0];
            b2_plz_reg <= b1_uz_reg * b1_d_reg[23:0];
            b2_phx_reg <= b1_ux_reg * b1_d_reg[40:24];
            b2_phy_reg <= b1_uy_reg * b1_d_reg[40:24];
            b2_phz_reg <= b1_uz_reg * b1_d_reg[40:24];
            b2_xn_reg  <= b1_xn_reg;
            b2_yn_reg  <= b1_yn_reg;
            b2_zn_reg  <= b1_zn_reg;
            b2_tx_reg  <= sat32(tx_w);
            b2_ty_reg  <= sat32(ty_w);
            b2_tz_reg  <= sat32(tz_w);
            b2_ok_reg  <= b1_ok_reg;

            b3_ex_reg <= b2_xn_reg ? -ex_mag : ex_mag;
            b3_ey_reg <= b2_yn_reg ? -ey_mag : ey_mag;
            b3_ez_reg <= b2_zn_reg ? -ez_mag : ez_mag;
            b3_tx_reg <= b2_tx_reg;
            b3_ty_reg <= b2_ty_reg;
            b3_tz_reg <= b2_tz_reg;
            b3_ok_reg <= b2_ok_reg;

            res_reg.ok         <= b3_ok_reg;
            res_reg.new_eye_x  <= b3_ok_reg ? sat32(nx_w) : '0;
            res_reg.new_eye_y  <= b3_ok_reg ? sat32(ny_w) : '0;
            res_reg.new_eye_z  <= b3_ok_reg ? sat32(nz_w) : '0;
            res_reg.new_look_x <= b3_ok_reg ? b3_tx_reg : '0;
            res_reg.new_look_y <= b3_ok_reg ? b3_ty_reg : '0;
            res_reg.new_look_z <= b3_ok_reg ? b3_tz_reg : '0;
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/core/orbit_camera_rescale_top.sv @@
`timescale 1ns / 1ps

// Orbit camera rescale. A word on the cam channel carries an eye position and a look-at
// target in signed Q16.16; each accepted word yields exactly one word on the res channel
// with the rebuilt eye and target and an ok flag (all coordinates zero when not ok).
// The block takes one word per cycle while the receiver does not stall. A word passes
// through three front stages, the 33 root steps of the length square root, the 33 quotient
// steps of the normalizing divider and four back stages.
// The configuration registers are written through the cfg channel, which is always
// ready; write them only while no word is in flight.
// Reset clears the valid bits and loads the configuration defaults (unit yaw, unit
// distance scale, zero clamp and offsets).
// When the receiver stalls with a result waiting, the whole pipeline holds and cam_stall
// rises in the same cycle, so no word is lost or repeated.

module orbit_camera_rescale_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cam_valid,
    output logic          cam_stall,
    input  ocr_pkg::cam_t cam,
    output logic          res_valid,
    input  logic          res_stall,
    output ocr_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import ocr_pkg::*;

    logic signed [15:0] yaw_cos_reg;
    logic signed [15:0] yaw_sin_reg;
    logic [15:0]        distance_scale_reg;
    logic [30:0]        minimum_distance_reg;
    logic signed [31:0] vertical_offset_reg;
    logic signed [31:0] sideways_offset_reg;
    logic [31:0]        off_mag_reg;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  en;

    logic [65:0] vsq, hsq;
    p1_t         p1_in;
    p1_t         p1_reg [SQRT_STEPS];
    p2_t         p2_in;
    p2_t         p2_reg [DIV_STEPS];
    p1_t         p1_last;
    logic [32:0] len, lenh;
    logic [32:0] qx, qy, qz, qpx, qpy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_cos_reg          <= 16'sd16384;
            yaw_sin_reg          <= '0;
            distance_scale_reg   <= 16'd256;
            minimum_distance_reg <= '0;
            vertical_offset_reg  <= '0;
            sideways_offset_reg  <= '0;
            off_mag_reg          <= '0;
        end else begin
            off_mag_reg <= sideways_offset_reg[31] ? -sideways_offset_reg : sideways_offset_reg;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_YAW_COS:          yaw_cos_reg          <= cfg_data[15:0];
                    CFG_YAW_SIN:          yaw_sin_reg          <= cfg_data[15:0];
                    CFG_DISTANCE_SCALE:   distance_scale_reg   <= cfg_data[15:0];
                    CFG_MINIMUM_DISTANCE: minimum_distance_reg <= cfg_data[30:0];
                    CFG_VERTICAL_OFFSET:  vertical_offset_reg  <= cfg_data;
                    CFG_SIDEWAYS_OFFSET:  sideways_offset_reg  <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    assign en        = !(vld_reg[PIPE_DEPTH-1] && res_stall);
    assign cam_stall = !en;
    assign res_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], cam_valid};
        end
    end

    ocr_front u_front (
        .clk             (clk),
        .en              (en),
        .cam             (cam),
        .yaw_cos         (yaw_cos_reg),
        .yaw_sin         (yaw_sin_reg),
        .vertical_offset (vertical_offset_reg),
        .vsq             (vsq),
        .hsq             (hsq),
        .p1              (p1_in)
    );

    ocr_sqrt u_sqrt_len (.clk(clk), .en(en), .radicand(vsq), .root(len));
    ocr_sqrt u_sqrt_hor (.clk(clk), .en(en), .radicand(hsq), .root(lenh));

    assign p1_last = p1_reg[SQRT_STEPS-1];

    always_comb
    begin
        p2_in.lx      = p1_last.lx;
        p2_in.ly      = p1_last.ly;
        p2_in.tz      = p1_last.tz;
        p2_in.rx_neg  = p1_last.rx_neg;
        p2_in.ry_neg  = p1_last.ry_neg;
        p2_in.rz_neg  = p1_last.rz_neg;
        p2_in.px_neg  = !p1_last.vy_neg;
        p2_in.py_neg  = p1_last.vx_neg;
        p2_in.dprod   = len * distance_scale_reg;
        p2_in.short_v = p1_last.short_v;
        p2_in.short_h = p1_last.short_h;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= p1_in;
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                p1_reg[i] <= p1_reg[i-1];
            end
            p2_reg[0] <= p2_in;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                p2_reg[i] <= p2_reg[i-1];
            end
        end
    end

    ocr_div u_div_x (.clk(clk), .en(en), .num({1'b0, p1_last.rxm, 16'b0}), .den(len), .quo(qx));
    ocr_div u_div_y (.clk(clk), .en(en), .num({1'b0, p1_last.rym, 16'b0}), .den(len), .quo(qy));
    ocr_div u_div_z (.clk(clk), .en(en), .num({1'b0, p1_last.rzm, 16'b0}), .den(len), .quo(qz));
    ocr_div u_div_px (.clk(clk), .en(en), .num({3'b0, p1_last.vym, 30'b0}), .den(lenh),
                      .quo(qpx));
    ocr_div u_div_py (.clk(clk), .en(en), .num({3'b0, p1_last.vxm, 30'b0}), .den(lenh),
                      .quo(qpy));

    ocr_back u_back (
        .clk              (clk),
        .en               (en),
        .p2               (p2_reg[DIV_STEPS-1]),
        .qx               (qx),
        .qy               (qy),
        .qz               (qz),
        .qpx              (qpx),
        .qpy              (qpy),
        .minimum_distance (minimum_distance_reg),
        .off_mag          (off_mag_reg),
        .off_neg          (sideways_offset_reg[31]),
        .off_nz           (sideways_offset_reg != '0),
        .res              (res)
    );

endmodule

@@ rtl/core/ocr_check.sv @@
`timescale 1ns / 1ps

module ocr_check (
    input logic          clk,
    input logic          rst_n,
    input logic          cam_stall,
    input logic          res_valid,
    input logic          res_stall,
    input ocr_pkg::res_t res
);
    import ocr_pkg::*;

    // A held result stays put until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // A rejected pair carries all-zero coordinates.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.ok |-> res.new_eye_x == '0 && res.new_eye_y == '0 &&
            res.new_eye_z == '0 && res.new_look_x == '0 && res.new_look_y == '0 &&
            res.new_look_z == '0)
        else $error("rejected result has nonzero coordinates");

    // The input side is held back exactly when a waiting result is stalled.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        cam_stall == (res_valid && res_stall))
        else $error("input stall does not follow output stall");

endmodule

bind orbit_camera_rescale_top ocr_check u_check (.*);
